// File: sv/grayscale_point_operation_assert.svh
// ----------------------------------------------------------------------------
// Grayscale point operation assertion macros
// Concurrent check helpers used by the point operation pipeline.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_POINT_OPERATION_ASSERT_SVH
`define GRAYSCALE_POINT_OPERATION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define GPO_ASSERT_IMP(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define GPO_ASSERT_NXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: sv/gpo_pkg.sv
// ----------------------------------------------------------------------------
// Grayscale point operation package
// Register indexes, mode codes, field widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package gpo_pkg;

    // Field and register widths
    localparam int GRAY_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 3;
    localparam int PCT_W      = 7;

    // Percent scale of the level compares
    localparam int PCT_SCALE = 100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GRAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE     = 3'd4;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_NEGATIVE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_THRESHOLD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WHITE_HALF = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLACK_HALF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LEVELS     = 3'd4;

    // Register reset values
    localparam logic [MODE_W-1:0] RST_MODE      = MODE_NEGATIVE;
    localparam logic [GRAY_W-1:0] RST_MAX_GRAY  = 16'd255;
    localparam logic [PCT_W-1:0]  RST_THRESHOLD = 7'd50;
    localparam logic [PCT_W-1:0]  RST_BLACK     = 7'd10;
    localparam logic [PCT_W-1:0]  RST_WHITE     = 7'd90;

endpackage

`default_nettype wire

// File: sv/grayscale_point_operation.sv
// ----------------------------------------------------------------------------
// Grayscale point operation unit
// Stages: capture, multiply, compare, one restoring divider stage per quotient
// bit, output register. One item per cycle unless the output stalls.
// Synchronous reset clears the stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grayscale_point_operation_assert.svh"

module grayscale_point_operation #(
    parameter int PIXEL_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // pixel input channel
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [gpo_pkg::GRAY_W-1:0]       i_pixel_in,
    input  wire                              i_last_in_image,
    // pixel output channel
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [gpo_pkg::GRAY_W-1:0]       o_pixel_out,
    output logic                             o_last_out,
    // configuration write port
    input  wire                              i_cfg_wen,
    input  wire  [gpo_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [gpo_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import gpo_pkg::*;

    // pixel*100 and percent*max both fit in PW bits
    localparam int PW     = PIXEL_BITS + PCT_W;
    localparam int NDIV   = PIXEL_BITS;
    localparam int ST_DIV = 3;
    localparam int NST    = NDIV + 4;
    localparam int ST_OUT = NST - 1;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] r_mode;
    logic [GRAY_W-1:0] r_max_gray;
    logic [PCT_W-1:0]  r_thr;
    logic [PCT_W-1:0]  r_black;
    logic [PCT_W-1:0]  r_white;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= RST_MODE;
            r_max_gray <= RST_MAX_GRAY;
            r_thr      <= RST_THRESHOLD;
            r_black    <= RST_BLACK;
            r_white    <= RST_WHITE;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_MODE:      r_mode     <= i_cfg_data[MODE_W-1:0];
                CFG_MAX_GRAY:  r_max_gray <= i_cfg_data[GRAY_W-1:0];
                CFG_THRESHOLD: r_thr      <= i_cfg_data[PCT_W-1:0];
                CFG_BLACK:     r_black    <= i_cfg_data[PCT_W-1:0];
                CFG_WHITE:     r_white    <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when any stage at or after it
    // is empty, or the output item is taken (bubbles collapse)
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] stage_en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        localparam logic [NST-1:0] LOW_MASK = (NST'(1) << k) - NST'(1);
        assign stage_en[k] = i_out_ready | ~(&(r_vld | LOW_MASK));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~stage_en) | ({r_vld[NST-2:0], i_in_valid} & stage_en);
        end
    end

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_vld[ST_OUT];

    // ------------------------------------------------------------------
    // Stage 1: capture item, saturate max, snapshot config
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] n_s1_max;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [PIXEL_BITS-1:0] r_s1_max;
    logic                  r_s1_last;
    logic [MODE_W-1:0]     r_s1_mode;
    logic [PCT_W-1:0]      r_s1_thr;
    logic [PCT_W-1:0]      r_s1_black;
    logic [PCT_W-1:0]      r_s1_white;

    assign n_s1_max = (r_max_gray > GRAY_W'(PIX_MAX)) ? PIX_MAX : r_max_gray[PIXEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1_pix   <= i_pixel_in[PIXEL_BITS-1:0];
            r_s1_max   <= n_s1_max;
            r_s1_last  <= i_last_in_image;
            r_s1_mode  <= r_mode;
            r_s1_thr   <= r_thr;
            r_s1_black <= r_black;
            r_s1_white <= r_white;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scaled pixel and the three percent levels
    // ------------------------------------------------------------------
    logic [PW-1:0]         r_s2_p100;
    logic [PW-1:0]         r_s2_thr_lvl;
    logic [PW-1:0]         r_s2_lo;
    logic [PW-1:0]         r_s2_hi;
    logic [PCT_W-1:0]      r_s2_span;
    logic [PIXEL_BITS-1:0] r_s2_pix;
    logic [PIXEL_BITS-1:0] r_s2_max;
    logic [MODE_W-1:0]     r_s2_mode;
    logic                  r_s2_last;

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_s2_p100    <= PW'(r_s1_pix) * PW'(PCT_SCALE);
            r_s2_thr_lvl <= PW'(r_s1_thr) * PW'(r_s1_max);
            r_s2_lo      <= PW'(r_s1_black) * PW'(r_s1_max);
            r_s2_hi      <= PW'(r_s1_white) * PW'(r_s1_max);
            r_s2_span    <= r_s1_white - r_s1_black;
            r_s2_pix     <= r_s1_pix;
            r_s2_max     <= r_s1_max;
            r_s2_mode    <= r_s1_mode;
            r_s2_last    <= r_s1_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compares and mode select; middle band goes to the divider
    // ------------------------------------------------------------------
    logic                  above;
    logic                  lt_lo;
    logic                  gt_lo;
    logic                  lt_hi;
    logic                  gt_hi;
    logic [PIXEL_BITS-1:0] n_s3_res;
    logic                  n_s3_use_div;

    assign above = r_s2_p100 > r_s2_thr_lvl;
    assign lt_lo = r_s2_p100 < r_s2_lo;
    assign gt_lo = r_s2_p100 > r_s2_lo;
    assign lt_hi = r_s2_p100 < r_s2_hi;
    assign gt_hi = r_s2_p100 > r_s2_hi;

    always_comb begin
        n_s3_res     = r_s2_pix;
        n_s3_use_div = 1'b0;
        case (r_s2_mode)
            MODE_NEGATIVE:   n_s3_res = (r_s2_pix > r_s2_max) ? '0 : (r_s2_max - r_s2_pix);
            MODE_THRESHOLD:  n_s3_res = above ? r_s2_max : '0;
            MODE_WHITE_HALF: n_s3_res = above ? r_s2_max : r_s2_pix;
            MODE_BLACK_HALF: n_s3_res = above ? r_s2_pix : '0;
            MODE_LEVELS: begin
                if (lt_lo) begin
                    n_s3_res = '0;
                end else if (gt_lo && lt_hi) begin
                    n_s3_use_div = 1'b1;
                end else if (gt_hi) begin
                    n_s3_res = r_s2_max;
                end else begin
                    n_s3_res = r_s2_pix;
                end
            end
            default: n_s3_res = r_s2_pix;
        endcase
    end

    logic [PIXEL_BITS-1:0] r_s3_res;
    logic                  r_s3_use_div;
    logic [PW-1:0]         r_s3_num;
    logic [PCT_W-1:0]      r_s3_span;
    logic                  r_s3_last;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_s3_res     <= n_s3_res;
            r_s3_use_div <= n_s3_use_div;
            r_s3_num     <= r_s2_p100 - r_s2_lo;
            r_s3_span    <= r_s2_span;
            r_s3_last    <= r_s2_last;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, MSB first.
    // The quotient stays below max, so PIXEL_BITS bits suffice.
    // ------------------------------------------------------------------
    logic [PW-1:0]         r_d_rem  [NDIV];
    logic [PIXEL_BITS-1:0] r_d_q    [NDIV];
    logic [PCT_W-1:0]      r_d_span [NDIV];
    logic [PIXEL_BITS-1:0] r_d_res  [NDIV];
    logic                  r_d_use  [NDIV];
    logic                  r_d_last [NDIV];

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        localparam int QB = NDIV - 1 - k;

        logic [PW-1:0]         prev_rem;
        logic [PIXEL_BITS-1:0] prev_q;
        logic [PCT_W-1:0]      prev_span;
        logic [PIXEL_BITS-1:0] prev_res;
        logic                  prev_use;
        logic                  prev_last;
        logic [PW-1:0]         dvs;
        logic                  fits;

        if (k == 0) begin : g_first
            assign prev_rem  = r_s3_num;
            assign prev_q    = '0;
            assign prev_span = r_s3_span;
            assign prev_res  = r_s3_res;
            assign prev_use  = r_s3_use_div;
            assign prev_last = r_s3_last;
        end else begin : g_next
            assign prev_rem  = r_d_rem[k-1];
            assign prev_q    = r_d_q[k-1];
            assign prev_span = r_d_span[k-1];
            assign prev_res  = r_d_res[k-1];
            assign prev_use  = r_d_use[k-1];
            assign prev_last = r_d_last[k-1];
        end

        assign dvs  = PW'(prev_span) << QB;
        assign fits = prev_rem >= dvs;

        always_ff @(posedge i_clk) begin
            if (stage_en[ST_DIV+k]) begin
                r_d_rem[k]  <= fits ? (prev_rem - dvs) : prev_rem;
                r_d_q[k]    <= fits ? (prev_q | (PIXEL_BITS'(1) << QB)) : prev_q;
                r_d_span[k] <= prev_span;
                r_d_res[k]  <= prev_res;
                r_d_use[k]  <= prev_use;
                r_d_last[k] <= prev_last;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] r_out_pix;
    logic                  r_out_last;

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_OUT]) begin
            r_out_pix  <= r_d_use[NDIV-1] ? r_d_q[NDIV-1] : r_d_res[NDIV-1];
            r_out_last <= r_d_last[NDIV-1];
        end
    end

    assign o_pixel_out = GRAY_W'(r_out_pix);
    assign o_last_out  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic div_check;
    logic div_rem_ok;

    // last divider stage holds a real quotient
    assign div_check  = r_vld[ST_OUT-1] && r_d_use[NDIV-1];
    assign div_rem_ok = r_d_rem[NDIV-1] < PW'(r_d_span[NDIV-1]);

    `GPO_ASSERT_NXT(a_accept_s1, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0], "item lost")
    `GPO_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, !o_in_ready, &r_vld, "stall with a bubble")
    `GPO_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, div_check, div_rem_ok, "bad remainder")

endmodule

`default_nettype wire
